>>> src/pfsu_pkg.sv
// shared types, codes and constants of the pcm byte fifo sample unpacker
`default_nettype none
package pfsu_pkg;

   localparam int FIFO_DEPTH_DEF = 1024;
   localparam int BYTE_W         = 8;
   localparam int SAMPLE_W       = 16;
   localparam int LEVEL_W        = 11;
   localparam int OP_W           = 2;
   localparam int CSR_ADDR_W     = 2;
   localparam int CSR_DATA_W     = 32;
   localparam int LENGTH_W       = 32;
   localparam int NEED_W         = 3;
   localparam int MAX_NEED       = 4;

   localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
   localparam logic [OP_W-1:0] OP_TAKE   = 2'd1;
   localparam logic [OP_W-1:0] OP_REWIND = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

   localparam logic [CSR_ADDR_W-1:0] CSR_WIDE    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEREO  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOOPING = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LENGTH  = 2'd3;

   localparam logic [BYTE_W-1:0] BYTE_OFFSET = 8'd128;

   typedef struct packed {
      logic wide_samples;
      logic stereo;
   } pfsu_mode_type;

   typedef struct packed {
      pfsu_mode_type       mode;
      logic                looping;
      logic [LENGTH_W-1:0] data_length;
   } pfsu_cfg_type;

   typedef logic [MAX_NEED-1:0][BYTE_W-1:0] pfsu_bytes_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
   } pfsu_pair_type;

   function automatic logic [NEED_W-1:0] need_bytes(input pfsu_mode_type mode);
      logic [NEED_W-1:0] n;
      case ({mode.wide_samples, mode.stereo})
         2'b00:   n = 3'd1;
         2'b01:   n = 3'd2;
         2'b10:   n = 3'd2;
         default: n = 3'd4;
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

>>> src/pfsu_ifs.sv
// request, response and register write channel interfaces
`default_nettype none
interface pfsu_req_if import pfsu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [BYTE_W-1:0] byte_in;

   modport source (output valid, output operation, output byte_in, input ready);
   modport sink (input valid, input operation, input byte_in, output ready);
endinterface

interface pfsu_rsp_if import pfsu_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_sample;
   logic signed [SAMPLE_W-1:0] right_sample;
   logic                       sample_ok;
   logic                       byte_taken;
   logic                       finished;
   logic [LEVEL_W-1:0]         level;

   modport source (output valid, output left_sample, output right_sample,
                   output sample_ok, output byte_taken, output finished,
                   output level, input ready);
   modport sink (input valid, input left_sample, input right_sample,
                 input sample_ok, input byte_taken, input finished,
                 input level, output ready);
endinterface

interface pfsu_csr_if import pfsu_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output addr, output data, input ready);
   modport sink (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

>>> src/pfsu_byte_ram.sv
// single port byte store with registered read data
`default_nettype none
module pfsu_byte_ram import pfsu_pkg::*; #(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
   localparam int AW = $clog2(FIFO_DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [AW-1:0]     addr,
   input  wire logic [BYTE_W-1:0] wdata,
   output logic      [BYTE_W-1:0] rdata
);

   logic [BYTE_W-1:0] store_mem [FIFO_DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_mem[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= store_mem[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> src/pfsu_sample_fmt.sv
// unpacks gathered bytes into left and right 16-bit samples
`default_nettype none
module pfsu_sample_fmt import pfsu_pkg::*; (
   input  wire pfsu_mode_type  mode,
   input  wire pfsu_bytes_type bytes,
   output pfsu_pair_type       pair
);

   logic [SAMPLE_W-1:0] narrow_left;
   logic [SAMPLE_W-1:0] narrow_right;
   logic [SAMPLE_W-1:0] wide_left;
   logic [SAMPLE_W-1:0] wide_right;

   // unsigned 8-bit to signed 16-bit
   assign narrow_left  = {bytes[0] - BYTE_OFFSET, {BYTE_W{1'b0}}};
   assign narrow_right = {bytes[1] - BYTE_OFFSET, {BYTE_W{1'b0}}};
   // little-endian words
   assign wide_left    = {bytes[1], bytes[0]};
   assign wide_right   = {bytes[3], bytes[2]};

   always_comb begin
      if (mode.wide_samples) begin
         pair.left_sample  = wide_left;
         pair.right_sample = mode.stereo ? wide_right : wide_left;
      end else begin
         pair.left_sample  = narrow_left;
         pair.right_sample = mode.stereo ? narrow_right : narrow_left;
      end
   end

endmodule
`default_nettype wire

>>> src/pfsu_seq.sv
// request sequencer: fifo bookkeeping, byte gathering and response register
`default_nettype none
module pfsu_seq import pfsu_pkg::*; #(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
   localparam int AW = $clog2(FIFO_DEPTH),
   localparam int FW = $clog2(FIFO_DEPTH + 1)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire pfsu_cfg_type               cfg,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [OP_W-1:0]            req_operation,
   input  wire logic [BYTE_W-1:0]          req_byte_in,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0]      rsp_left_sample,
   output logic signed [SAMPLE_W-1:0]      rsp_right_sample,
   output logic                            rsp_sample_ok,
   output logic                            rsp_byte_taken,
   output logic                            rsp_finished,
   output logic [LEVEL_W-1:0]              rsp_level,
   output logic                            mem_we,
   output logic [AW-1:0]                   mem_addr,
   output logic [BYTE_W-1:0]               mem_wdata,
   input  wire logic [BYTE_W-1:0]          mem_rdata
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_READ   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [AW-1:0]       wr_pos_ff, wr_pos_in;
   logic [AW-1:0]       rd_pos_ff, rd_pos_in;
   logic [FW-1:0]       fill_ff, fill_in;
   logic [LENGTH_W-1:0] pass_ff, pass_in;
   logic                done_ff, done_in;
   logic [NEED_W-1:0]   cnt_ff, cnt_in;
   logic                cap_ff, cap_in;
   logic [1:0]          cap_idx_ff, cap_idx_in;
   pfsu_bytes_type      bytes_ff, bytes_in;
   logic                res_ok_ff, res_ok_in;
   logic                res_taken_ff, res_taken_in;

   logic                       out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0] out_left_ff, out_left_in;
   logic signed [SAMPLE_W-1:0] out_right_ff, out_right_in;
   logic                       out_ok_ff, out_ok_in;
   logic                       out_taken_ff, out_taken_in;
   logic                       out_done_ff, out_done_in;
   logic [LEVEL_W-1:0]         out_level_ff, out_level_in;

   logic              accept;
   logic              pass_ex;
   logic              slot_free;
   logic              can_store;
   logic [NEED_W-1:0] need;
   logic [FW-1:0]     need_fw;
   logic [AW-1:0]     wr_next;
   logic [AW-1:0]     rd_next;
   pfsu_pair_type     pair;

   pfsu_sample_fmt u_fmt (
      .mode  (cfg.mode),
      .bytes (bytes_ff),
      .pair  (pair)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign pass_ex   = (pass_ff >= cfg.data_length);
   assign slot_free = !out_valid_ff || rsp_ready;
   assign need      = need_bytes(cfg.mode);
   assign need_fw   = FW'(need);
   assign wr_next   = (wr_pos_ff == AW'(FIFO_DEPTH - 1)) ? '0 : wr_pos_ff + AW'(1);
   assign rd_next   = (rd_pos_ff == AW'(FIFO_DEPTH - 1)) ? '0 : rd_pos_ff + AW'(1);

   always_comb begin
      state_in     = state_ff;
      wr_pos_in    = wr_pos_ff;
      rd_pos_in    = rd_pos_ff;
      fill_in      = fill_ff;
      pass_in      = pass_ff;
      done_in      = done_ff;
      cnt_in       = cnt_ff;
      cap_in       = cap_ff;
      cap_idx_in   = cap_idx_ff;
      bytes_in     = bytes_ff;
      res_ok_in    = res_ok_ff;
      res_taken_in = res_taken_ff;
      can_store    = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = rd_pos_ff;
      mem_wdata    = req_byte_in;

      out_valid_in = out_valid_ff && !rsp_ready;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;
      out_ok_in    = out_ok_ff;
      out_taken_in = out_taken_ff;
      out_done_in  = out_done_ff;
      out_level_in = out_level_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_ok_in    = 1'b0;
               res_taken_in = 1'b0;
               state_in     = ST_FINISH;
               case (req_operation)
                  OP_PUSH: begin
                     if (!done_ff && fill_ff < FW'(FIFO_DEPTH)) begin
                        can_store = 1'b1;
                        if (pass_ex) begin
                           if (cfg.looping) begin
                              pass_in   = '0;
                              can_store = (cfg.data_length != '0);
                           end else begin
                              if (fill_ff == '0) begin
                                 done_in = 1'b1;
                              end
                              can_store = 1'b0;
                           end
                        end
                        if (can_store) begin
                           mem_we       = 1'b1;
                           mem_addr     = wr_pos_ff;
                           wr_pos_in    = wr_next;
                           fill_in      = fill_ff + FW'(1);
                           pass_in      = pass_in + LENGTH_W'(1);
                           res_taken_in = 1'b1;
                        end
                     end
                  end
                  OP_TAKE: begin
                     if (fill_ff < need_fw) begin
                        if (pass_ex && !cfg.looping && fill_ff == '0) begin
                           done_in = 1'b1;
                        end
                     end else begin
                        fill_in   = fill_ff - need_fw;
                        cnt_in    = '0;
                        res_ok_in = 1'b1;
                        state_in  = ST_READ;
                     end
                  end
                  OP_REWIND: begin
                     wr_pos_in = '0;
                     rd_pos_in = '0;
                     fill_in   = '0;
                     pass_in   = '0;
                     done_in   = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            cap_in = 1'b0;
            if (cnt_ff < need) begin
               mem_addr   = rd_pos_ff;
               rd_pos_in  = rd_next;
               cnt_in     = cnt_ff + NEED_W'(1);
               cap_in     = 1'b1;
               cap_idx_in = cnt_ff[1:0];
            end
            if (cap_ff) begin
               bytes_in[cap_idx_ff] = mem_rdata;
            end
            if (cap_ff && cnt_ff == need) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_left_in  = res_ok_ff ? pair.left_sample : '0;
               out_right_in = res_ok_ff ? pair.right_sample : '0;
               out_ok_in    = res_ok_ff;
               out_taken_in = res_taken_ff;
               out_done_in  = done_ff;
               out_level_in = LEVEL_W'(fill_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_pos_ff    <= '0;
         rd_pos_ff    <= '0;
         fill_ff      <= '0;
         pass_ff      <= '0;
         done_ff      <= 1'b0;
         cnt_ff       <= '0;
         cap_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_pos_ff    <= wr_pos_in;
         rd_pos_ff    <= rd_pos_in;
         fill_ff      <= fill_in;
         pass_ff      <= pass_in;
         done_ff      <= done_in;
         cnt_ff       <= cnt_in;
         cap_ff       <= cap_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_idx_ff   <= cap_idx_in;
      bytes_ff     <= bytes_in;
      res_ok_ff    <= res_ok_in;
      res_taken_ff <= res_taken_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
      out_ok_ff    <= out_ok_in;
      out_taken_ff <= out_taken_in;
      out_done_ff  <= out_done_in;
      out_level_ff <= out_level_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_left_sample  = out_left_ff;
   assign rsp_right_sample = out_right_ff;
   assign rsp_sample_ok    = out_ok_ff;
   assign rsp_byte_taken   = out_taken_ff;
   assign rsp_finished     = out_done_ff;
   assign rsp_level        = out_level_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(FIFO_DEPTH))
      else $error("fill count above fifo depth");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_IDLE && accept))
      else $error("store write outside request acceptance");

   a_read_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (cnt_ff <= need))
      else $error("more bytes gathered than the sample needs");

   a_load_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && slot_free) |=> (out_valid_ff && state_ff == ST_IDLE))
      else $error("finished request not loaded into response register");

endmodule
`default_nettype wire

>>> src/pcm_byte_fifo_sample_unpacker.sv
// pcm byte fifo sample unpacker top level
//
// requests arrive on req_chan: operation push stores byte_in in the byte fifo,
// take removes 1, 2 or 4 bytes and unpacks one left/right sample pair, rewind
// clears the fifo, the pass count and the finished flag, the fourth code does
// nothing. every request gives exactly one response on rsp_chan.
// csr_chan writes the sample mode, looping and pass length; it is always ready
// and should only be written while no request is in flight.
// push, rewind, no-op and a take that underruns go from acceptance straight
// to the finish state, which loads the response register once it is free; a
// successful take first gathers N bytes in the read state, N being the bytes
// per sample (1, 2 or 4), as the single store port reads one byte per cycle
// with registered read data. a new request is accepted only once the last one
// has loaded its response register.
// the response register holds while rsp_chan.ready is low; the next request is
// still accepted and worked, and waits only to load its own response.
// reset clears positions, counts and flags and loads the register reset values;
// store contents are not cleared and no clearing pass runs.
`default_nettype none
module pcm_byte_fifo_sample_unpacker import pfsu_pkg::*; #(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   pfsu_req_if.sink   req_chan,
   pfsu_rsp_if.source rsp_chan,
   pfsu_csr_if.sink   csr_chan
);

   localparam int AW = $clog2(FIFO_DEPTH);

   logic                wide_ff, wide_in;
   logic                stereo_ff, stereo_in;
   logic                looping_ff, looping_in;
   logic [LENGTH_W-1:0] length_ff, length_in;
   pfsu_cfg_type        cfg;

   logic              mem_we;
   logic [AW-1:0]     mem_addr;
   logic [BYTE_W-1:0] mem_wdata;
   logic [BYTE_W-1:0] mem_rdata;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      wide_in    = wide_ff;
      stereo_in  = stereo_ff;
      looping_in = looping_ff;
      length_in  = length_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.addr)
            CSR_WIDE:    wide_in    = csr_chan.data[0];
            CSR_STEREO:  stereo_in  = csr_chan.data[0];
            CSR_LOOPING: looping_in = csr_chan.data[0];
            CSR_LENGTH:  length_in  = csr_chan.data[LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff    <= 1'b1;
         stereo_ff  <= 1'b1;
         looping_ff <= 1'b0;
         length_ff  <= '0;
      end else begin
         wide_ff    <= wide_in;
         stereo_ff  <= stereo_in;
         looping_ff <= looping_in;
         length_ff  <= length_in;
      end
   end

   assign cfg.mode.wide_samples = wide_ff;
   assign cfg.mode.stereo       = stereo_ff;
   assign cfg.looping           = looping_ff;
   assign cfg.data_length       = length_ff;

   pfsu_byte_ram #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   pfsu_seq #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_operation    (req_chan.operation),
      .req_byte_in      (req_chan.byte_in),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_left_sample  (rsp_chan.left_sample),
      .rsp_right_sample (rsp_chan.right_sample),
      .rsp_sample_ok    (rsp_chan.sample_ok),
      .rsp_byte_taken   (rsp_chan.byte_taken),
      .rsp_finished     (rsp_chan.finished),
      .rsp_level        (rsp_chan.level),
      .mem_we           (mem_we),
      .mem_addr         (mem_addr),
      .mem_wdata        (mem_wdata),
      .mem_rdata        (mem_rdata)
   );

endmodule
`default_nettype wire
